### sv/mean_and_sample_variance_macros.svh
`ifndef MEAN_AND_SAMPLE_VARIANCE_MACROS_SVH
`define MEAN_AND_SAMPLE_VARIANCE_MACROS_SVH

// same-cycle implication
`define MSV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/msv_pkg.sv
package msv_pkg;

  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned MEAN_W          = 24;
  localparam int unsigned VAR_W           = 39;
  localparam int unsigned FRAC_W          = 8;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned DEF_MAX_SAMPLES = 1024;

  localparam logic [VAR_W-1:0] VAR_MAX = '1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_SINGLE,
    ST_OVERFLOW
  } msv_status_e;

  typedef enum logic [2:0] {
    OP_DIV_MEAN,
    OP_MUL_NSQ,
    OP_MUL_MAG,
    OP_MUL_DEN,
    OP_DIV_VAR
  } msv_op_e;

  typedef struct packed {
    logic    acc;
    logic    start;
    msv_op_e op;
    logic    load_out;
  } msv_cmd_t;

  typedef struct packed {
    logic busy;
    logic n_lt2;
    logic out_free;
  } msv_sts_t;

endpackage

### sv/msv_ctrl.sv
module msv_ctrl
  import msv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  input  msv_sts_t sts_i,
  output msv_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_ACC,
    S_RUN,
    S_DONE
  } state_e;

  state_e  state_q;
  logic    start_q;
  msv_op_e op_q;

  assign in_ready_o     = (state_q == S_ACC);
  assign cmd_o.acc      = in_valid_i && in_ready_o;
  assign cmd_o.start    = start_q;
  assign cmd_o.op       = op_q;
  assign cmd_o.load_out = (state_q == S_DONE) && sts_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
      start_q <= 1'b0;
      op_q    <= OP_DIV_MEAN;
    end else begin
      case (state_q)
        S_ACC: begin
          if (cmd_o.acc && in_last_i) begin
            state_q <= S_RUN;
            start_q <= 1'b1;
            op_q    <= OP_DIV_MEAN;
          end
        end
        S_RUN: begin
          if (start_q) begin
            start_q <= 1'b0;
          end else if (!sts_i.busy) begin
            case (op_q)
              OP_DIV_MEAN: begin
                if (sts_i.n_lt2) begin
                  state_q <= S_DONE;
                end else begin
                  op_q    <= OP_MUL_NSQ;
                  start_q <= 1'b1;
                end
              end
              OP_MUL_NSQ: begin
                op_q    <= OP_MUL_MAG;
                start_q <= 1'b1;
              end
              OP_MUL_MAG: begin
                op_q    <= OP_MUL_DEN;
                start_q <= 1'b1;
              end
              OP_MUL_DEN: begin
                op_q    <= OP_DIV_VAR;
                start_q <= 1'b1;
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          if (sts_i.out_free) begin
            state_q <= S_ACC;
          end
        end
        default: begin
          state_q <= S_ACC;
        end
      endcase
    end
  end

endmodule

### sv/msv_datapath.sv
module msv_datapath
  import msv_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES,
  localparam int unsigned CNT_W      = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  msv_cmd_t                   cmd_i,
  output msv_sts_t                   sts_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [MEAN_W-1:0]   mean_q8_o,
  output logic [VAR_W-1:0]           variance_q8_o,
  output logic [CNT_W-1:0]           sample_count_o,
  output logic [STATUS_W-1:0]        status_o
);

  localparam int unsigned SUM_W  = SAMPLE_W + CNT_W;
  localparam int unsigned SQ_W   = 2 * SAMPLE_W - 2 + CNT_W;
  localparam int unsigned PROD_W = SQ_W + CNT_W;
  localparam int unsigned MPL_W  = SUM_W;
  localparam int unsigned DEN_W  = 2 * CNT_W;
  localparam int unsigned DIV_W  = PROD_W + FRAC_W;
  localparam int unsigned STEP_W = $clog2(DIV_W + 1);

  // accumulators
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SQ_W-1:0]         sq_q, sq_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    ovf_q, ovf_d;

  // shared shift-add multiplier and restoring divider
  logic                    busy_q, busy_d;
  msv_op_e                 op_q, op_d;
  logic [PROD_W-1:0]       mcand_q, mcand_d;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic [MPL_W-1:0]        mplier_q, mplier_d;
  logic [DIV_W-1:0]        dvd_q, dvd_d;
  logic [DEN_W-1:0]        rem_q, rem_d;
  logic [DEN_W-1:0]        dsr_q, dsr_d;
  logic [STEP_W-1:0]       step_q, step_d;

  // intermediate results
  logic [MEAN_W-1:0]       mean_q, mean_d;
  logic [VAR_W-1:0]        var_q, var_d;
  logic [PROD_W-1:0]       tmp_q, tmp_d;
  logic [DEN_W-1:0]        den_q, den_d;

  // output register
  logic                    out_valid_q, out_valid_d;
  logic [MEAN_W-1:0]       out_mean_q, out_mean_d;
  logic [VAR_W-1:0]        out_var_q, out_var_d;
  logic [CNT_W-1:0]        out_cnt_q, out_cnt_d;
  msv_status_e             out_status_q, out_status_d;

  logic signed [2*SAMPLE_W-1:0] sq_sample;
  logic [SUM_W-1:0]        mag;
  logic [CNT_W-1:0]        cnt_m1;
  logic                    full;
  logic                    is_mul;
  logic                    finish;
  logic [DEN_W+1:0]        trial;
  logic                    borrow;

  always_comb begin
    sq_sample = sample_i * sample_i;
    mag       = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    cnt_m1    = cnt_q - 1'b1;
    full      = (cnt_q == CNT_W'(MAX_SAMPLES));
    is_mul    = op_q inside {OP_MUL_NSQ, OP_MUL_MAG, OP_MUL_DEN};
    finish    = busy_q && (is_mul ? (mplier_q == '0) : (step_q == '0));
    trial     = {1'b0, rem_q, dvd_q[DIV_W-1]} - {2'b00, dsr_q};
    borrow    = trial[DEN_W+1];

    sts_o.busy     = busy_q;
    sts_o.n_lt2    = (cnt_q < CNT_W'(2));
    sts_o.out_free = !out_valid_q || out_ready_i;

    sum_d        = sum_q;
    sq_d         = sq_q;
    cnt_d        = cnt_q;
    ovf_d        = ovf_q;
    busy_d       = busy_q;
    op_d         = op_q;
    mcand_d      = mcand_q;
    prod_d       = prod_q;
    mplier_d     = mplier_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    dsr_d        = dsr_q;
    step_d       = step_q;
    mean_d       = mean_q;
    var_d        = var_q;
    tmp_d        = tmp_q;
    den_d        = den_q;
    out_valid_d  = out_valid_q;
    out_mean_d   = out_mean_q;
    out_var_d    = out_var_q;
    out_cnt_d    = out_cnt_q;
    out_status_d = out_status_q;

    if (cmd_i.acc) begin
      if (!full) begin
        sum_d = sum_q + SUM_W'(sample_i);
        sq_d  = sq_q + SQ_W'($unsigned(sq_sample));
        cnt_d = cnt_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end

    if (cmd_i.start) begin
      busy_d = 1'b1;
      op_d   = cmd_i.op;
      prod_d = '0;
      rem_d  = '0;
      step_d = STEP_W'(DIV_W);
      case (cmd_i.op)
        OP_DIV_MEAN: begin
          dvd_d = DIV_W'(mag) << FRAC_W;
          dsr_d = DEN_W'(cnt_q);
        end
        OP_DIV_VAR: begin
          dvd_d = DIV_W'(tmp_q) << FRAC_W;
          dsr_d = den_q;
        end
        OP_MUL_NSQ: begin
          mcand_d  = PROD_W'(sq_q);
          mplier_d = MPL_W'(cnt_q);
        end
        OP_MUL_MAG: begin
          mcand_d  = PROD_W'(mag);
          mplier_d = mag;
        end
        OP_MUL_DEN: begin
          mcand_d  = PROD_W'(cnt_q);
          mplier_d = MPL_W'(cnt_m1);
        end
        default: begin
        end
      endcase
    end else if (busy_q) begin
      if (finish) begin
        busy_d = 1'b0;
        case (op_q)
          OP_DIV_MEAN: begin
            mean_d = sum_q[SUM_W-1] ? -dvd_q[MEAN_W-1:0] : dvd_q[MEAN_W-1:0];
            var_d  = '0;
          end
          OP_MUL_NSQ: tmp_d = prod_q;
          OP_MUL_MAG: tmp_d = tmp_q - prod_q;
          OP_MUL_DEN: den_d = prod_q[DEN_W-1:0];
          OP_DIV_VAR: begin
            var_d = (dvd_q > DIV_W'(VAR_MAX)) ? VAR_MAX : dvd_q[VAR_W-1:0];
          end
          default: begin
          end
        endcase
      end else if (is_mul) begin
        prod_d   = prod_q + (mplier_q[0] ? mcand_q : '0);
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
      end else begin
        rem_d  = borrow ? {rem_q[DEN_W-2:0], dvd_q[DIV_W-1]} : trial[DEN_W-1:0];
        dvd_d  = {dvd_q[DIV_W-2:0], ~borrow};
        step_d = step_q - 1'b1;
      end
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
      out_mean_d  = mean_q;
      out_var_d   = var_q;
      out_cnt_d   = cnt_q;
      if (ovf_q) begin
        out_status_d = ST_OVERFLOW;
      end else if (cnt_q < CNT_W'(2)) begin
        out_status_d = ST_SINGLE;
      end else begin
        out_status_d = ST_OK;
      end
      sum_d = '0;
      sq_d  = '0;
      cnt_d = '0;
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      sq_q        <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      busy_q      <= 1'b0;
      op_q        <= OP_DIV_MEAN;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      sq_q        <= sq_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      busy_q      <= busy_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q      <= mcand_d;
    prod_q       <= prod_d;
    mplier_q     <= mplier_d;
    dvd_q        <= dvd_d;
    rem_q        <= rem_d;
    dsr_q        <= dsr_d;
    step_q       <= step_d;
    mean_q       <= mean_d;
    var_q        <= var_d;
    tmp_q        <= tmp_d;
    den_q        <= den_d;
    out_mean_q   <= out_mean_d;
    out_var_q    <= out_var_d;
    out_cnt_q    <= out_cnt_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o    = out_valid_q;
  assign mean_q8_o      = out_mean_q;
  assign variance_q8_o  = out_var_q;
  assign sample_count_o = out_cnt_q;
  assign status_o       = out_status_q;

endmodule

### sv/mean_and_sample_variance.sv
// Samples: one transfer per cycle while a list accumulates.
// After the last sample, a one-sample list needs only the restoring divide for the mean.
// Any other list runs two restoring divides (mean, then variance) around three
// shift-add multiplies (n*sum of squares, |sum|^2, n*(n-1)), then the result load.
// No input is taken until the result moves into the output register.
// Reset (rst_ni low, async) clears the accumulators, the sequencer and out_valid.
module mean_and_sample_variance
  import msv_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES,
  localparam int unsigned CNT_W      = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [MEAN_W-1:0]   mean_q8_o,
  output logic [VAR_W-1:0]           variance_q8_o,
  output logic [CNT_W-1:0]           sample_count_o,
  output logic [STATUS_W-1:0]        status_o
);

  msv_cmd_t cmd;
  msv_sts_t sts;

  msv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (last_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  msv_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (sample_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .mean_q8_o      (mean_q8_o),
    .variance_q8_o  (variance_q8_o),
    .sample_count_o (sample_count_o),
    .status_o       (status_o)
  );

endmodule

### sv/msv_checker.sv
`include "mean_and_sample_variance_macros.svh"

module msv_checker
  import msv_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES,
  localparam int unsigned CNT_W      = $clog2(MAX_SAMPLES + 1)
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic signed [SAMPLE_W-1:0] sample_i,
  input logic                       last_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [MEAN_W-1:0]   mean_q8_o,
  input logic [VAR_W-1:0]           variance_q8_o,
  input logic [CNT_W-1:0]           sample_count_o,
  input logic [STATUS_W-1:0]        status_o
);

  `MSV_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i && $stable(sample_i) && $stable(last_i), "input changed while stalled")

  `MSV_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(mean_q8_o) && $stable(variance_q8_o) && $stable(status_o), "result changed while stalled")

  `MSV_ASSERT_IMP(a_single, clk_i, rst_ni, out_valid_o && status_o == ST_SINGLE, variance_q8_o == '0 && sample_count_o == CNT_W'(1), "single-sample result malformed")

  `MSV_ASSERT_IMP(a_ok_count, clk_i, rst_ni, out_valid_o && status_o == ST_OK, sample_count_o >= CNT_W'(2) && sample_count_o <= CNT_W'(MAX_SAMPLES), "ok result count out of range")

  `MSV_ASSERT_IMP(a_ovf_count, clk_i, rst_ni, out_valid_o && status_o == ST_OVERFLOW, sample_count_o == CNT_W'(MAX_SAMPLES), "overflow result not at full count")

endmodule

bind mean_and_sample_variance msv_checker #(.MAX_SAMPLES(MAX_SAMPLES)) u_msv_checker (.*);

### sim/mean_and_sample_variance_test.sv
module mean_and_sample_variance_test;
  timeunit 1ns;
  timeprecision 1ps;
  import msv_pkg::*;

  localparam int unsigned MAX_N        = DEF_MAX_SAMPLES;
  localparam int unsigned CNT_W        = $clog2(MAX_N + 1);
  localparam int unsigned RANDOM_ITEMS = 925;
  localparam int unsigned LATE_CALM    = 100;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 250;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]         variance;
    logic [CNT_W-1:0]         count;
    msv_status_e              status;
  } stats_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       lst;
    logic                       typed;
    stats_t                     res;
  } dir_row_t;

  localparam stats_t NO_RES = '0;

  localparam dir_row_t DIR_ROWS [21] = '{
    '{16'sh0000, 1'b1, 1'b1, '{24'sh000000, 39'd0, CNT_W'(1), ST_SINGLE}},
    '{16'sh8000, 1'b1, 1'b1, '{24'sh800000, 39'd0, CNT_W'(1), ST_SINGLE}},
    '{16'sh7FFF, 1'b1, 1'b1, '{24'sd8388352, 39'd0, CNT_W'(1), ST_SINGLE}},
    '{16'sh8000, 1'b0, 1'b0, NO_RES},
    '{16'sh7FFF, 1'b1, 1'b1, '{-24'sd128, 39'd549739036800, CNT_W'(2), ST_OK}},
    '{16'sh7FFF, 1'b0, 1'b0, NO_RES},
    '{16'sh7FFF, 1'b1, 1'b1, '{24'sd8388352, 39'd0, CNT_W'(2), ST_OK}},
    '{16'sh8000, 1'b0, 1'b0, NO_RES},
    '{16'sh8000, 1'b1, 1'b1, '{24'sh800000, 39'd0, CNT_W'(2), ST_OK}},
    '{16'sh0001, 1'b0, 1'b0, NO_RES},
    '{16'shFFFF, 1'b0, 1'b0, NO_RES},
    '{16'sh0002, 1'b0, 1'b0, NO_RES},
    '{16'shFFFE, 1'b0, 1'b0, NO_RES},
    '{16'sh0003, 1'b1, 1'b0, NO_RES},
    '{16'sh5555, 1'b0, 1'b0, NO_RES},
    '{16'shAAAA, 1'b0, 1'b0, NO_RES},
    '{16'sh00FF, 1'b0, 1'b0, NO_RES},
    '{16'shFF00, 1'b1, 1'b0, NO_RES},
    '{16'shFFFF, 1'b0, 1'b0, NO_RES},
    '{16'shFFFF, 1'b0, 1'b0, NO_RES},
    '{16'sh0000, 1'b1, 1'b0, NO_RES}
  };

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_i;
  logic                       last_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [MEAN_W-1:0]   mean_q8_o;
  logic [VAR_W-1:0]           variance_q8_o;
  logic [CNT_W-1:0]           sample_count_o;
  logic [STATUS_W-1:0]        status_o;

  // running statistics of the list being sent
  logic signed [26:0] acc_sum;
  logic [40:0]        acc_sq_sum;
  logic [CNT_W-1:0]   acc_count;
  logic               acc_over;

  stats_t      pending_stats_q [$];
  int          errors;
  int unsigned results_seen;
  int unsigned samples_sent;
  int unsigned lists_sent;
  int unsigned status_hits [3];
  int unsigned gap_pct;
  bit          calm;
  bit          hold_req;

  mean_and_sample_variance u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .mean_q8_o     (mean_q8_o),
    .variance_q8_o (variance_q8_o),
    .sample_count_o(sample_count_o),
    .status_o      (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("%0t: timeout, %0d results still expected", $time, pending_stats_q.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit fold_sample(input logic signed [SAMPLE_W-1:0] s, input logic lst,
                                     output stats_t res);
    u64_t   nu;
    u64_t   mag;
    u64_t   num;
    u64_t   den;
    u64_t   quo;
    u64_t   rem;
    u64_t   v;
    longint sum;
    longint mean_full;
    res = NO_RES;
    if (acc_count < MAX_N) begin
      acc_sum    = acc_sum + 27'(s);
      acc_sq_sum = acc_sq_sum + 41'(longint'(s) * longint'(s));
      acc_count  = acc_count + 1'b1;
    end else begin
      acc_over = 1'b1;
    end
    if (!lst) return 1'b0;
    nu        = u64_t'(acc_count);
    sum       = longint'(acc_sum);
    mean_full = (sum * 256) / longint'(nu);
    res.mean  = MEAN_W'(mean_full);
    if (nu >= 2) begin
      mag = (sum < 0) ? u64_t'(-sum) : u64_t'(sum);
      num = nu * u64_t'(acc_sq_sum) - mag * mag;
      den = nu * (nu - 1);
      quo = num / den;
      rem = num % den;
      if (quo > (64'(VAR_MAX) >> FRAC_W)) begin
        v = 64'(VAR_MAX);
      end else begin
        v = quo * 256 + (rem * 256) / den;
        if (v > 64'(VAR_MAX)) v = 64'(VAR_MAX);
      end
      res.variance = VAR_W'(v);
    end
    res.count  = acc_count;
    res.status = acc_over ? ST_OVERFLOW : ((nu < 2) ? ST_SINGLE : ST_OK);
    acc_sum    = '0;
    acc_sq_sum = '0;
    acc_count  = '0;
    acc_over   = 1'b0;
    return 1'b1;
  endfunction

  task automatic offer_sample(input logic signed [SAMPLE_W-1:0] s, input logic lst,
                              input logic typed, input stats_t typed_res);
    stats_t      res;
    int unsigned gap;
    if (!calm && $urandom_range(99) < gap_pct) begin
      gap = $urandom_range(7, 1);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    sample_i   <= s;
    last_i     <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    samples_sent++;
    if (lst) lists_sent++;
    if (fold_sample(s, lst, res)) pending_stats_q.push_back(typed ? typed_res : res);
  endtask

  // receive side: random ready bursts, one long hold-off on request
  initial begin
    int unsigned low_left;
    int unsigned idle_pct;
    low_left    = 0;
    idle_pct    = 20;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(127) == 0) begin
        case ($urandom_range(2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 50;
        endcase
      end
      if (low_left == 0) begin
        if (hold_req) begin
          low_left = HOLD_CYCLES;
          hold_req = 1'b0;
        end else if (!calm && $urandom_range(99) < idle_pct) begin
          low_left = $urandom_range(7, 1);
        end
      end
      out_ready_i <= (low_left == 0) && rst_ni;
      if (low_left != 0) low_left--;
    end
  end

  always @(posedge clk_i) begin : check_results
    stats_t exp_s;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_stats_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, mean %0d var %0d count %0d status %0d", $time,
                 mean_q8_o, variance_q8_o, sample_count_o, status_o);
      end else begin
        exp_s = pending_stats_q.pop_front();
        results_seen++;
        status_hits[exp_s.status]++;
        if (mean_q8_o !== exp_s.mean) begin
          errors++;
          $display("%0t: mean_q8 expected %0d got %0d", $time, exp_s.mean, mean_q8_o);
        end
        if (variance_q8_o !== exp_s.variance) begin
          errors++;
          $display("%0t: variance_q8 expected %0d got %0d", $time, exp_s.variance,
                   variance_q8_o);
        end
        if (sample_count_o !== exp_s.count) begin
          errors++;
          $display("%0t: sample_count expected %0d got %0d", $time, exp_s.count,
                   sample_count_o);
        end
        if (status_o !== exp_s.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, exp_s.status, status_o);
        end
      end
    end
  end

  initial begin
    logic signed [SAMPLE_W-1:0] s;
    int unsigned                len;
    int unsigned                pick;
    int unsigned                rnd_items;
    int unsigned                list_idx;
    in_valid_i   = 1'b0;
    sample_i     = '0;
    last_i       = 1'b0;
    rst_ni       = 1'b0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    gap_pct      = 20;
    errors       = 0;
    results_seen = 0;
    samples_sent = 0;
    lists_sent   = 0;
    status_hits  = '{0, 0, 0};
    acc_sum      = '0;
    acc_sq_sum   = '0;
    acc_count    = '0;
    acc_over     = 1'b0;
    rnd_items    = 0;
    list_idx     = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIR_ROWS[i])
      offer_sample(DIR_ROWS[i].smp, DIR_ROWS[i].lst, DIR_ROWS[i].typed, DIR_ROWS[i].res);

    while (rnd_items < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 10) len = 1;
      else if (pick < 75) len = $urandom_range(8, 2);
      else if (pick < 95) len = $urandom_range(40, 9);
      else len = $urandom_range(200, 41);
      case ($urandom_range(2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 40;
      endcase
      if (list_idx == 12) hold_req = 1'b1;
      if (list_idx == 30) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (pending_stats_q.size() != 0) @(posedge clk_i);
      end
      if (rnd_items + LATE_CALM >= RANDOM_ITEMS) calm = 1'b1;
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(9))
          0, 1: begin
            case ($urandom_range(4))
              0: s = 16'sh8000;
              1: s = 16'sh7FFF;
              2: s = 16'sh0000;
              3: s = 16'shFFFF;
              default: s = 16'sh0001;
            endcase
          end
          2, 3: s = SAMPLE_W'(int'($urandom_range(16)) - 8);
          default: s = SAMPLE_W'($urandom);
        endcase
        offer_sample(s, k == len - 1, 1'b0, NO_RES);
        rnd_items++;
      end
      list_idx++;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    for (int w = 0; w < 5000 && pending_stats_q.size() != 0; w++) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_stats_q.size() != 0) begin
      errors += pending_stats_q.size();
      $display("%0t: %0d results never arrived", $time, pending_stats_q.size());
    end
    $display("Sent %0d samples in %0d lists: extreme values, random lengths, a long hold-off",
             samples_sent, lists_sent);
    $display("Checked %0d results: %0d ok, %0d single sample, %0d overflow, %0d errors",
             results_seen, status_hits[ST_OK], status_hits[ST_SINGLE],
             status_hits[ST_OVERFLOW], errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
